// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; clk and rst_n are taken from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive while in reset.
`define CHK_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("same-cycle check failed");

// Next-cycle implication, inactive while in reset.
`define CHK_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define CHK_NXT_ALL(lbl, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("reset check failed");

`endif

// ===== hw/rtl/gbn_pkg.sv =====
package gbn_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_FILL_OUT,
    ST_ACK_RD,
    ST_ACK_CMP,
    ST_TICK_CHK,
    ST_REJECT
  } gbn_state_t;

  typedef enum logic [1:0] {
    OP_QUEUE  = 2'd0,
    OP_ACK    = 2'd1,
    OP_TICK   = 2'd2,
    OP_UNUSED = 2'd3
  } gbn_op_t;

  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_RESEND = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [1:0] REG_WINDOW  = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_START   = 2'd2;

  localparam logic [5:0]  WIN_CAP     = 6'd32;
  localparam logic [5:0]  RST_WINDOW  = 6'd10;
  localparam logic [15:0] RST_TIMEOUT = 16'd1000;
  localparam logic [31:0] RST_START   = 32'd1001;

  localparam int SEQ_W  = 32;
  localparam int LEN_W  = 11;
  localparam int SLOT_W = 6;

endpackage

// ===== hw/rtl/gbn_ram.sv =====
module gbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/go_back_n_sender_window_top.sv =====
// Go-Back-N sender window, one item worked at a time; in_stall is high while busy.
// Queue: write to ring; ST_FILL reads each sendable segment, ST_FILL_OUT registers it.
// Ack: ST_ACK_RD reads and ST_ACK_CMP frees each acked segment; then as for queue.
// Tick: ST_TICK_CHK checks the head age; a resend rewinds to head, then as for queue.
// Next item is taken once ST_FILL finds nothing to send; out_stall holds the beat states.
// Reset (rst_n, synchronous): pointers, counts, tick to zero; config to defaults; RAM kept.
module go_back_n_sender_window_top
  import gbn_pkg::*;
#(
  parameter int RING_DEPTH = 64,
  parameter int MAX_LEN    = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [LEN_W-1:0]  in_seg_length,
  input  logic [SEQ_W-1:0]  in_ack_number,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [SLOT_W-1:0] out_slot,
  output logic [SEQ_W-1:0]  out_seq_number,
  output logic [LEN_W-1:0]  out_seg_len_out,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int AW   = $clog2(RING_DEPTH);
  localparam int CW   = $clog2(RING_DEPTH + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;
  localparam int SLW  = SEQ_W + LEN_W;

  gbn_state_t        state_r, state_nxt;
  logic [5:0]        window_r, window_nxt;
  logic [15:0]       timeout_r, timeout_nxt;
  logic [SEQ_W-1:0]  next_seq_r, next_seq_nxt;
  logic [31:0]       tick_now_r, tick_now_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [AW-1:0]     unsent_r, unsent_nxt;
  logic [CW-1:0]     queued_r, queued_nxt;
  logic [5:0]        unacked_r, unacked_nxt;
  logic [5:0]        was_r, was_nxt;
  logic [SEQ_W-1:0]  ack_r, ack_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [SEQ_W-1:0]  out_seq_r, out_seq_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;
  logic              out_last_r, out_last_nxt;

  logic              sl_we, sl_re;
  logic [AW-1:0]     sl_waddr, sl_raddr;
  logic [SLW-1:0]    sl_wdata, sl_rdata;
  logic              st_we, st_re;
  logic [AW-1:0]     st_waddr;
  logic [31:0]       st_wdata, st_rdata;

  logic [5:0]        eff_win;
  logic [CMPW-1:0]   win_ext, unacked_ext, unacked_inc, queued_ext;
  logic              can_send, more_after;
  logic              out_free, in_acc, ring_full;
  logic [16:0]       len_ext;
  logic [LEN_W-1:0]  len_sat;
  logic [SEQ_W-1:0]  head_seq_inc;
  logic [31:0]       age;
  logic [SLOT_W-1:0] slot_ext;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] q;
    q = (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    return q;
  endfunction

  gbn_ram #(.WIDTH(SLW), .DEPTH(RING_DEPTH)) u_seq_len_ram (
    .clk   (clk),
    .we    (sl_we),
    .waddr (sl_waddr),
    .wdata (sl_wdata),
    .re    (sl_re),
    .raddr (sl_raddr),
    .rdata (sl_rdata)
  );

  gbn_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_stamp_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (head_r),
    .rdata (st_rdata)
  );

  assign eff_win = (window_r == 6'd0) ? 6'd1 : ((window_r > WIN_CAP) ? WIN_CAP : window_r);
  assign win_ext     = CMPW'(eff_win);
  assign unacked_ext = CMPW'(unacked_r);
  assign unacked_inc = unacked_ext + 1'b1;
  assign queued_ext  = CMPW'(queued_r);
  assign can_send    = (unacked_ext < win_ext) && (unacked_ext < queued_ext);
  assign more_after  = (unacked_inc < win_ext) && (unacked_inc < queued_ext);

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign ring_full = (queued_r == CW'(RING_DEPTH));
  assign cfg_ready = 1'b1;

  assign len_ext = 17'(in_seg_length);
  assign len_sat = (len_ext > 17'(MAX_LEN)) ? LEN_W'(MAX_LEN) : in_seg_length;

  assign head_seq_inc = sl_rdata[SLW-1:LEN_W] + 1'b1;
  assign age          = tick_now_r - st_rdata;
  assign slot_ext     = SLOT_W'(unsent_r);

  always_comb begin
    state_nxt     = state_r;
    window_nxt    = window_r;
    timeout_nxt   = timeout_r;
    next_seq_nxt  = next_seq_r;
    tick_now_nxt  = tick_now_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    unsent_nxt    = unsent_r;
    queued_nxt    = queued_r;
    unacked_nxt   = unacked_r;
    was_nxt       = was_r;
    ack_nxt       = ack_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_seq_nxt   = out_seq_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    sl_we         = 1'b0;
    sl_waddr      = tail_r;
    sl_wdata      = {next_seq_r, len_sat};
    sl_re         = 1'b0;
    sl_raddr      = unsent_r;
    st_we         = 1'b0;
    st_waddr      = tail_r;
    st_wdata      = tick_now_r;
    st_re         = 1'b0;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW:  window_nxt   = cfg_data[5:0];
        REG_TIMEOUT: timeout_nxt  = cfg_data[15:0];
        REG_START:   next_seq_nxt = cfg_data;
        default:     ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (gbn_op_t'(in_op))
            OP_QUEUE: begin
              if (ring_full) begin
                state_nxt = ST_REJECT;
              end else begin
                sl_we        = 1'b1;
                st_we        = 1'b1;
                tail_nxt     = ptr_inc(tail_r);
                queued_nxt   = queued_r + 1'b1;
                next_seq_nxt = next_seq_r + 1'b1;
                was_nxt      = '0;
                state_nxt    = ST_FILL;
              end
            end
            OP_ACK: begin
              ack_nxt   = in_ack_number;
              was_nxt   = '0;
              state_nxt = ST_ACK_RD;
            end
            OP_TICK: begin
              tick_now_nxt = tick_now_r + 1'b1;
              if (queued_r != '0) begin
                st_re     = 1'b1;
                state_nxt = ST_TICK_CHK;
              end
            end
            OP_UNUSED: ;
          endcase
        end
      end
      ST_REJECT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_REJECT;
          out_slot_nxt  = '0;
          out_seq_nxt   = '0;
          out_len_nxt   = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_ACK_RD: begin
        if ((unacked_r != '0) && (queued_r != '0)) begin
          sl_re     = 1'b1;
          sl_raddr  = head_r;
          state_nxt = ST_ACK_CMP;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_ACK_CMP: begin
        if (head_seq_inc <= ack_r) begin
          head_nxt    = ptr_inc(head_r);
          queued_nxt  = queued_r - 1'b1;
          unacked_nxt = unacked_r - 1'b1;
          state_nxt   = ST_ACK_RD;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_TICK_CHK: begin
        if (age > {16'b0, timeout_r}) begin
          was_nxt     = unacked_r;
          unacked_nxt = '0;
          unsent_nxt  = head_r;
          state_nxt   = ST_FILL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (can_send) begin
          sl_re     = 1'b1;
          state_nxt = ST_FILL_OUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FILL_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = (unacked_r < was_r) ? KIND_RESEND : KIND_FIRST;
          out_slot_nxt  = slot_ext;
          out_seq_nxt   = sl_rdata[SLW-1:LEN_W];
          out_len_nxt   = sl_rdata[LEN_W-1:0];
          out_last_nxt  = !more_after;
          st_we         = 1'b1;
          st_waddr      = unsent_r;
          unacked_nxt   = unacked_r + 1'b1;
          unsent_nxt    = ptr_inc(unsent_r);
          state_nxt     = ST_FILL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= RST_WINDOW;
      timeout_r   <= RST_TIMEOUT;
      next_seq_r  <= RST_START;
      tick_now_r  <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      unsent_r    <= '0;
      queued_r    <= '0;
      unacked_r   <= '0;
      was_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      timeout_r   <= timeout_nxt;
      next_seq_r  <= next_seq_nxt;
      tick_now_r  <= tick_now_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      unsent_r    <= unsent_nxt;
      queued_r    <= queued_nxt;
      unacked_r   <= unacked_nxt;
      was_r       <= was_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ack_r      <= ack_nxt;
    out_kind_r <= out_kind_nxt;
    out_slot_r <= out_slot_nxt;
    out_seq_r  <= out_seq_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_slot        = out_slot_r;
  assign out_seq_number  = out_seq_r;
  assign out_seg_len_out = out_len_r;
  assign out_last        = out_last_r;

endmodule

// ===== hw/rtl/gbn_chk.sv =====
`include "assert_macros.svh"

module gbn_chk
  import gbn_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_kind,
  input logic [SLOT_W-1:0] out_slot,
  input logic [SEQ_W-1:0]  out_seq_number,
  input logic [LEN_W-1:0]  out_seg_len_out,
  input logic              out_last
);

  // handshake
  `CHK_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `CHK_NXT(a_out_seq_stable, out_valid && out_stall, $stable(out_seq_number))

  // block behaviour
  `CHK_NXT_ALL(a_reset_ready, !rst_n, !in_stall)
  `CHK_IMP(a_reject_beat, out_valid && (out_kind == KIND_REJECT), out_last && (out_slot == '0) && (out_seq_number == '0) && (out_seg_len_out == '0))
  `CHK_IMP(a_len_bound, out_valid, 17'(out_seg_len_out) <= 17'(MAX_LEN))

endmodule

bind go_back_n_sender_window_top gbn_chk #(.MAX_LEN(MAX_LEN)) u_gbn_chk (.*);
